// ===== hw/rtl/nsq_pkg.sv =====
// nsq_pkg: shared constants and types for the receiver sentence queue
package nsq_pkg;

	// default sizes
	localparam int DefQueueLines = 8;
	localparam int DefLineBytes  = 128;

	// operation codes
	localparam logic [1:0] OpFeed     = 2'd0;
	localparam logic [1:0] OpReadLine = 2'd1;
	localparam logic [1:0] OpReadGga  = 2'd2;

	// sentence parsing constants
	localparam logic [7:0] NewlineChar = 8'h0A;
	localparam logic [7:0] CharG       = 8'h47;
	localparam logic [7:0] CharA       = 8'h41;
	localparam int         GgaTagPos   = 3;
	localparam int         GgaMinLen   = 6;

	// control from the line ring to the gga buffer on a feed transaction
	typedef struct packed {
		logic wr_en;
		logic line_end;
		logic capture;
	} feed_t;

	// result of one character read
	typedef struct packed {
		logic [7:0] out_char;
		logic       last;
		logic       none;
	} rd_res_t;

endpackage

// ===== hw/rtl/nsq_if.sv =====
// nsq_if: valid/ready channel interfaces for commands and responses

interface nsq_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] in_byte;
	logic [7:0] max_chars;

	modport source (output valid, output op, output in_byte, output max_chars, input ready);
	modport sink (input valid, input op, input in_byte, input max_chars, output ready);
endinterface

interface nsq_out_if #(
	parameter int LQW = 4
);
	logic           valid;
	logic           ready;
	logic [7:0]     out_char;
	logic           last_char;
	logic           none_available;
	logic           line_complete;
	logic           gga_captured;
	logic           line_dropped;
	logic [LQW-1:0] lines_queued;

	modport source (output valid, output out_char, output last_char, output none_available,
		output line_complete, output gga_captured, output line_dropped, output lines_queued,
		input ready);
	modport sink (input valid, input out_char, input last_char, input none_available,
		input line_complete, input gga_captured, input line_dropped, input lines_queued,
		output ready);
endinterface

// ===== hw/rtl/nmea_sentence_queue.sv =====
// nmea_sentence_queue: top level with handshake sequencing and response register
//
//   channel  dir  handshake      payload
//   cmd      in   valid/ready    op, in_byte, max_chars
//   rsp      out  valid/ready    out_char, last_char, none_available, line_complete,
//                                gga_captured, line_dropped, lines_queued
//
// each transaction reads the line and gga memories when the command is accepted, then
// evaluates and writes back in the execute state, since the memory read is registered.
// the response register lets a new command be accepted while a response waits.
// reset clears pointers, counts and flags only; memories need no clearing pass.
// a response still held by the sink stalls the execute step, not command accept.
module nmea_sentence_queue #(
	parameter int QUEUE_LINES = nsq_pkg::DefQueueLines,
	parameter int LINE_BYTES  = nsq_pkg::DefLineBytes
) (
	input  logic      clk,
	input  logic      arst_n,
	nsq_in_if.sink    cmd,
	nsq_out_if.source rsp
);
	import nsq_pkg::*;

	localparam int PW = $clog2(LINE_BYTES);
	localparam int CW = $clog2(QUEUE_LINES + 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t     state_q;
	logic [1:0] op_s1;
	logic [7:0] in_byte_s1, max_chars_s1;
	logic       out_valid_q;
	logic       issue, exec;

	feed_t         feed;
	logic [PW-1:0] wr_pos, copy_len;
	rd_res_t       line_res, gga_res;
	logic          dropped;
	logic [CW-1:0] count_next;

	// handshake control
	assign cmd.ready = (state_q == ST_IDLE);
	assign issue     = cmd.valid && (state_q == ST_IDLE);
	assign exec      = (state_q == ST_EXEC) && (!out_valid_q || rsp.ready);
	assign rsp.valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (issue) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (exec) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// command capture
	always_ff @(posedge clk) begin
		if (issue) begin
			op_s1        <= cmd.op;
			in_byte_s1   <= cmd.in_byte;
			max_chars_s1 <= cmd.max_chars;
		end
	end

	nsq_ring #(
		.QUEUE_LINES (QUEUE_LINES),
		.LINE_BYTES  (LINE_BYTES),
		.PW          (PW),
		.CW          (CW)
	) u_ring (
		.clk        (clk),
		.arst_n     (arst_n),
		.issue      (issue),
		.exec       (exec),
		.op         (issue ? cmd.op : op_s1),
		.in_byte    (in_byte_s1),
		.max_chars  (max_chars_s1),
		.feed       (feed),
		.wr_pos     (wr_pos),
		.copy_len   (copy_len),
		.line_res   (line_res),
		.dropped    (dropped),
		.count_next (count_next)
	);

	nsq_gga #(
		.LINE_BYTES (LINE_BYTES),
		.PW         (PW)
	) u_gga (
		.clk      (clk),
		.arst_n   (arst_n),
		.issue    (issue),
		.exec     (exec),
		.op       (op_s1),
		.in_byte  (in_byte_s1),
		.feed     (feed),
		.wr_pos   (wr_pos),
		.copy_len (copy_len),
		.gga_res  (gga_res)
	);

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			rsp.out_char       <= line_res.out_char | gga_res.out_char;
			rsp.last_char      <= line_res.last | gga_res.last;
			rsp.none_available <= line_res.none | gga_res.none;
			rsp.line_complete  <= feed.line_end;
			rsp.gga_captured   <= feed.capture;
			rsp.line_dropped   <= dropped;
			rsp.lines_queued   <= count_next;
		end
	end

	a_issue_exec: assert property (@(posedge clk) disable iff (!arst_n)
		issue |=> state_q == ST_EXEC)
		else $error("accepted command did not enter execute");

	a_exec_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXEC |-> !cmd.ready)
		else $error("command accepted during execute");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXEC && out_valid_q && !rsp.ready |=> state_q == ST_EXEC)
		else $error("execute step passed a held response");

	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EXEC))
		else $error("response raised outside execute");

endmodule

// ===== hw/rtl/nsq_ring.sv =====
// nsq_ring: line assembly in place and ring of completed lines in one memory
module nsq_ring #(
	parameter int QUEUE_LINES = nsq_pkg::DefQueueLines,
	parameter int LINE_BYTES  = nsq_pkg::DefLineBytes,
	parameter int PW          = $clog2(LINE_BYTES),
	parameter int CW          = $clog2(QUEUE_LINES + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             issue,
	input  logic             exec,
	input  logic [1:0]       op,
	input  logic [7:0]       in_byte,
	input  logic [7:0]       max_chars,
	output nsq_pkg::feed_t   feed,
	output logic [PW-1:0]    wr_pos,
	output logic [PW-1:0]    copy_len,
	output nsq_pkg::rd_res_t line_res,
	output logic             dropped,
	output logic [CW-1:0]    count_next
);
	import nsq_pkg::*;

	localparam int SLOTS = QUEUE_LINES + 1;
	localparam int SW    = $clog2(SLOTS);
	localparam int EW    = (PW > 8) ? PW : 8;
	localparam logic [PW-1:0] MaxLen = PW'(LINE_BYTES - 1);

	// one slot more than the ring holds: the head slot is always free for assembly
	logic [7:0]    ring_mem [0:(1 << (SW + PW)) - 1];
	logic [PW-1:0] len_mem  [0:SLOTS-1];

	logic [SW-1:0] head_q, tail_q;
	logic [CW-1:0] count_q;
	logic [PW-1:0] rpos_q, line_len_q, copy_len_q;
	logic          zero_seen_q;
	logic          m3_q, m4_q, m5_q;
	logic [7:0]    rd_char_s2;
	logic [PW-1:0] rd_len_s2;

	logic          is_feed, is_read, line_end, push, pop, full, has_line;
	logic          deliver, last;
	logic [PW-1:0] len_new;
	logic [7:0]    limit;
	logic [EW-1:0] len_e, lim_e, eff, rpos_e, rpos_inc_e;
	logic [SW-1:0] head_inc, tail_inc;

	// feed side: byte write and line end
	always_comb begin
		is_feed  = (op == OpFeed);
		is_read  = (op == OpReadLine);
		feed.wr_en = is_feed && (line_len_q < MaxLen);
		len_new  = line_len_q + PW'(feed.wr_en);
		copy_len = (feed.wr_en && !zero_seen_q && (in_byte != 8'd0)) ?
			copy_len_q + PW'(1) : copy_len_q;
		line_end = is_feed && (in_byte == NewlineChar);
		feed.line_end = line_end;
		feed.capture  = line_end && (len_new > PW'(GgaMinLen)) && m3_q && m4_q && m5_q;
		full     = (count_q == CW'(QUEUE_LINES));
		push     = line_end && !full;
		dropped  = line_end && full;
		wr_pos   = line_len_q;
		head_inc = (head_q == SW'(SLOTS - 1)) ? '0 : head_q + SW'(1);
		tail_inc = (tail_q == SW'(SLOTS - 1)) ? '0 : tail_q + SW'(1);
	end

	// read side: clip to the reader limit and decide on pop
	always_comb begin
		has_line   = (count_q != '0);
		limit      = (max_chars == 8'd0) ? 8'd0 : max_chars - 8'd1;
		len_e      = EW'(rd_len_s2);
		lim_e      = EW'(limit);
		eff        = (len_e < lim_e) ? len_e : lim_e;
		rpos_e     = EW'(rpos_q);
		rpos_inc_e = rpos_e + EW'(1);
		deliver    = has_line && (rpos_e < eff);
		last       = has_line && (!deliver || (rpos_inc_e >= eff));
		pop        = is_read && last;
		line_res.out_char = (is_read && deliver) ? rd_char_s2 : 8'd0;
		line_res.last     = pop;
		line_res.none     = is_read && !has_line;
		if (push) begin
			count_next = count_q + CW'(1);
		end else if (pop) begin
			count_next = count_q - CW'(1);
		end else begin
			count_next = count_q;
		end
	end

	// memories: write in place at the head slot, read at the tail slot
	always_ff @(posedge clk) begin
		if (exec && feed.wr_en) begin
			ring_mem[{head_q, line_len_q}] <= in_byte;
		end
		if (exec && push) begin
			len_mem[head_q] <= copy_len;
		end
		if (issue) begin
			rd_char_s2 <= ring_mem[{tail_q, rpos_q}];
			rd_len_s2  <= len_mem[tail_q];
		end
	end

	// tag match flags for bytes three to five of the line
	always_ff @(posedge clk) begin
		if (exec && feed.wr_en) begin
			if (line_len_q == PW'(GgaTagPos)) begin
				m3_q <= (in_byte == CharG);
			end
			if (line_len_q == PW'(GgaTagPos + 1)) begin
				m4_q <= (in_byte == CharG);
			end
			if (line_len_q == PW'(GgaTagPos + 2)) begin
				m5_q <= (in_byte == CharA);
			end
		end
	end

	// pointers, counts and line assembly state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			rpos_q      <= '0;
			line_len_q  <= '0;
			copy_len_q  <= '0;
			zero_seen_q <= 1'b0;
		end else if (exec) begin
			count_q <= count_next;
			if (line_end) begin
				line_len_q  <= '0;
				copy_len_q  <= '0;
				zero_seen_q <= 1'b0;
			end else if (feed.wr_en) begin
				line_len_q <= len_new;
				copy_len_q <= copy_len;
				if (in_byte == 8'd0) begin
					zero_seen_q <= 1'b1;
				end
			end
			if (push) begin
				head_q <= head_inc;
			end
			if (pop) begin
				tail_q <= tail_inc;
				rpos_q <= '0;
			end else if (is_read && deliver) begin
				rpos_q <= rpos_q + PW'(1);
			end
		end
	end

	// ring bookkeeping checks
	logic [SW:0] tail_sum;
	logic [SW:0] tail_wrap;
	always_comb begin
		tail_sum  = {1'b0, tail_q} + (SW + 1)'(count_q);
		tail_wrap = (tail_sum >= (SW + 1)'(SLOTS)) ? tail_sum - (SW + 1)'(SLOTS) : tail_sum;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_LINES))
		else $error("ring count above capacity");

	a_head_tail: assert property (@(posedge clk) disable iff (!arst_n)
		tail_wrap[SW-1:0] == head_q)
		else $error("head does not match tail plus count");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		exec && push |=> count_q == $past(count_q) + CW'(1))
		else $error("push did not raise the count");

endmodule

// ===== hw/rtl/nsq_gga.sv =====
// nsq_gga: double-buffered capture of the latest gga sentence
module nsq_gga #(
	parameter int LINE_BYTES = nsq_pkg::DefLineBytes,
	parameter int PW         = $clog2(LINE_BYTES)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             issue,
	input  logic             exec,
	input  logic [1:0]       op,
	input  logic [7:0]       in_byte,
	input  nsq_pkg::feed_t   feed,
	input  logic [PW-1:0]    wr_pos,
	input  logic [PW-1:0]    copy_len,
	output nsq_pkg::rd_res_t gga_res
);
	import nsq_pkg::*;

	// bank cap_q holds the captured sentence, the other bank gathers the next line
	logic [7:0] gga_mem [0:(1 << (PW + 1)) - 1];

	logic          cap_q, fresh_q;
	logic [PW-1:0] glen_q, grp_q;
	logic [7:0]    gd_s2;

	logic          is_read, deliver, last;
	logic [PW-1:0] grp_inc;

	// character select and end of sentence
	always_comb begin
		is_read = (op == OpReadGga);
		deliver = fresh_q && (grp_q < glen_q);
		grp_inc = grp_q + PW'(deliver);
		last    = fresh_q && (grp_inc >= glen_q);
		gga_res.out_char = (is_read && deliver) ? gd_s2 : 8'd0;
		gga_res.last     = is_read && last;
		gga_res.none     = is_read && !fresh_q;
	end

	// mirror every stored line byte into the gathering bank
	always_ff @(posedge clk) begin
		if (exec && feed.wr_en) begin
			gga_mem[{~cap_q, wr_pos}] <= in_byte;
		end
		if (issue) begin
			gd_s2 <= gga_mem[{cap_q, grp_q}];
		end
	end

	// bank swap on capture, read position on reads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= 1'b0;
			fresh_q <= 1'b0;
			glen_q  <= '0;
			grp_q   <= '0;
		end else if (exec) begin
			if (feed.capture) begin
				cap_q   <= ~cap_q;
				glen_q  <= copy_len;
				fresh_q <= 1'b1;
				grp_q   <= '0;
			end else if (is_read && fresh_q) begin
				if (last) begin
					fresh_q <= 1'b0;
					grp_q   <= '0;
				end else begin
					grp_q <= grp_inc;
				end
			end
		end
	end

	a_capture_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		exec && feed.capture |=> fresh_q && (grp_q == '0) && (cap_q != $past(cap_q)))
		else $error("capture did not swap banks and mark fresh");

	a_grp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q |-> grp_q < glen_q || glen_q == '0)
		else $error("gga read position past sentence length");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		exec && gga_res.last |=> !fresh_q)
		else $error("last gga character did not clear fresh");

endmodule
